>>> rtl/core/bmx_pkg.sv
// Shared types, sizes and codes of the binary trie maximum-xor block.
package bmx_pkg;

  localparam int KEY_BITS   = 31;
  localparam int POOL_NODES = 65536;
  localparam int COUNT_BITS = 20;

  localparam int NODE_BITS = $clog2(POOL_NODES);
  localparam int LVL_BITS  = $clog2(KEY_BITS + 1);
  localparam int CHK_W     = NODE_BITS + 2;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 31;
  localparam int ANSWER_W = 31;
  localparam int STATUS_W = 2;

  localparam int IN_W      = CMD_W + VALUE_W;
  localparam int OUT_W     = ANSWER_W + STATUS_W;
  localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DATA_W - OUT_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd3;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [NODE_BITS-1:0]  link1;
    logic [NODE_BITS-1:0]  link0;
  } node_t;

  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] waddr;
    node_t                wdata;
    logic [NODE_BITS-1:0] raddr_a;
    logic [NODE_BITS-1:0] raddr_b;
  } mem_req_t;

endpackage

>>> rtl/core/bmx_node_mem.sv
// Trie node store: one write port and two registered read ports.
module bmx_node_mem (
  input  logic             clk,
  input  bmx_pkg::mem_req_t req,
  output bmx_pkg::node_t   rd_a,
  output bmx_pkg::node_t   rd_b
);

  bmx_pkg::node_t mem [bmx_pkg::POOL_NODES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

>>> rtl/core/binary_trie_max_xor_top.sv
// Top level of the binary trie maximum-xor block: command sequencer and result register.
//
// The block keeps a multiset of keys in a binary trie and answers insert, remove and
// maximum-xor query commands, one result per command. After reset it writes the path
// of a single zero key into the node store, during which s_tready stays low. Every walk
// visits one trie level per cycle through the node store. An insert takes a check walk
// and an update walk, a remove also a leaf check between the two; the check walk may end
// early. A query takes a root read and a query walk, ending early on an empty set; an
// unused command goes straight to the final state. s_tready rises again together with
// m_tvalid, as the result is loaded. The output register holds the result while the next
// command is already being taken; a result still waiting there holds the sequencer in its
// final state.
module binary_trie_max_xor_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bmx_pkg::IN_DATA_W-1:0]     s_tdata,   // cmd, value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bmx_pkg::OUT_DATA_W-1:0]    m_tdata    // answer, status
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_LEAF,
    S_UPD,
    S_QROOT,
    S_QRY,
    S_FIN
  } state_t;

  state_t                                state;
  logic [bmx_pkg::NODE_BITS-1:0]         init_idx;
  logic [bmx_pkg::CMD_W-1:0]             cmd_q;
  logic [bmx_pkg::KEY_BITS-1:0]          key_q;
  logic [bmx_pkg::KEY_BITS-1:0]          key_sh;
  logic [bmx_pkg::LVL_BITS-1:0]          left;
  logic                                  fresh;
  logic [bmx_pkg::NODE_BITS-1:0]         cur;
  logic [bmx_pkg::NODE_BITS:0]           nf;
  logic [bmx_pkg::KEY_BITS-1:0]          acc;
  logic                                  l0nz;
  logic                                  l1nz;
  logic [bmx_pkg::STATUS_W-1:0]          res_status;
  logic [bmx_pkg::ANSWER_W-1:0]          m_answer;
  logic [bmx_pkg::STATUS_W-1:0]          m_status;

  bmx_pkg::mem_req_t req;
  bmx_pkg::node_t    rd_a;
  bmx_pkg::node_t    rd_b;
  bmx_pkg::node_t    word;
  bmx_pkg::node_t    upd_word;
  bmx_pkg::node_t    chosen;

  logic                           dir;
  logic [bmx_pkg::NODE_BITS-1:0]  nx;
  logic                           at_root;
  logic                           pool_short;
  logic                           is_insert;
  logic                           c0nz;
  logic                           c1nz;
  logic                           want;
  logic                           hit;
  logic                           take1;
  logic [bmx_pkg::KEY_BITS-1:0]   acc_next;

  bmx_node_mem u_mem (
    .clk  (clk),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{bmx_pkg::OUT_PAD_W{1'b0}}, m_status, m_answer};

  assign word       = fresh ? '0 : rd_a;
  assign dir        = key_sh[bmx_pkg::KEY_BITS-1];
  assign nx         = dir ? word.link1 : word.link0;
  assign at_root    = (left == bmx_pkg::LVL_BITS'(bmx_pkg::KEY_BITS));
  assign is_insert  = (cmd_q == bmx_pkg::CMD_INSERT);
  assign pool_short = (bmx_pkg::CHK_W'(nf) + bmx_pkg::CHK_W'(left))
                      > bmx_pkg::CHK_W'(bmx_pkg::POOL_NODES);

  assign c0nz     = l0nz && (rd_a.count != '0);
  assign c1nz     = l1nz && (rd_b.count != '0);
  assign want     = ~dir;
  assign hit      = want ? c1nz : c0nz;
  assign take1    = hit ? want : ~want;
  assign chosen   = take1 ? rd_b : rd_a;
  assign acc_next = {acc[bmx_pkg::KEY_BITS-2:0], hit};

  always_comb begin
    upd_word = word;
    if (is_insert) begin
      upd_word.count = word.count + bmx_pkg::COUNT_BITS'(1);
      if (left != '0 && nx == '0) begin
        if (dir) begin
          upd_word.link1 = nf[bmx_pkg::NODE_BITS-1:0];
        end else begin
          upd_word.link0 = nf[bmx_pkg::NODE_BITS-1:0];
        end
      end
    end else begin
      upd_word.count = word.count - bmx_pkg::COUNT_BITS'(1);
    end
  end

  always_comb begin
    req = '0;
    unique case (state)
      S_INIT: begin
        req.we          = 1'b1;
        req.waddr       = init_idx;
        req.wdata.count = bmx_pkg::COUNT_BITS'(1);
        if (init_idx < bmx_pkg::NODE_BITS'(bmx_pkg::KEY_BITS)) begin
          req.wdata.link0 = init_idx + bmx_pkg::NODE_BITS'(1);
        end
      end
      S_CHECK: begin
        if (is_insert && left == bmx_pkg::LVL_BITS'(1)) begin
          req.raddr_a = '0;
        end else begin
          req.raddr_a = nx;
        end
      end
      S_UPD: begin
        req.we      = 1'b1;
        req.waddr   = cur;
        req.wdata   = upd_word;
        req.raddr_a = nx;
      end
      S_QROOT: begin
        req.raddr_a = rd_a.link0;
        req.raddr_b = rd_a.link1;
      end
      S_QRY: begin
        req.raddr_a = chosen.link0;
        req.raddr_b = chosen.link1;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      nf         <= (bmx_pkg::NODE_BITS+1)'(bmx_pkg::KEY_BITS + 1);
      fresh      <= 1'b0;
      m_tvalid   <= 1'b0;
      res_status <= bmx_pkg::STATUS_OK;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + bmx_pkg::NODE_BITS'(1);
          if (init_idx == bmx_pkg::NODE_BITS'(bmx_pkg::KEY_BITS)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q      <= s_tdata[bmx_pkg::CMD_W-1:0];
            key_q      <= bmx_pkg::KEY_BITS'(s_tdata[bmx_pkg::IN_W-1:bmx_pkg::CMD_W]);
            key_sh     <= bmx_pkg::KEY_BITS'(s_tdata[bmx_pkg::IN_W-1:bmx_pkg::CMD_W]);
            left       <= bmx_pkg::LVL_BITS'(bmx_pkg::KEY_BITS);
            acc        <= '0;
            fresh      <= 1'b0;
            res_status <= bmx_pkg::STATUS_OK;
            unique case (s_tdata[bmx_pkg::CMD_W-1:0])
              bmx_pkg::CMD_INSERT,
              bmx_pkg::CMD_REMOVE: state <= S_CHECK;
              bmx_pkg::CMD_QUERY:  state <= S_QROOT;
              default:             state <= S_FIN;
            endcase
          end
        end
        S_CHECK: begin
          if (is_insert && at_root && word.count == '1) begin
            res_status <= bmx_pkg::STATUS_SATURATED;
            state      <= S_FIN;
          end else if (nx == '0) begin
            if (!is_insert) begin
              res_status <= bmx_pkg::STATUS_ABSENT;
              state      <= S_FIN;
            end else if (pool_short) begin
              res_status <= bmx_pkg::STATUS_POOL_FULL;
              state      <= S_FIN;
            end else begin
              key_sh <= key_q;
              left   <= bmx_pkg::LVL_BITS'(bmx_pkg::KEY_BITS);
              cur    <= '0;
              state  <= S_UPD;
            end
          end else if (left == bmx_pkg::LVL_BITS'(1)) begin
            if (is_insert) begin
              key_sh <= key_q;
              left   <= bmx_pkg::LVL_BITS'(bmx_pkg::KEY_BITS);
              cur    <= '0;
              state  <= S_UPD;
            end else begin
              state <= S_LEAF;
            end
          end else begin
            key_sh <= key_sh << 1;
            left   <= left - bmx_pkg::LVL_BITS'(1);
          end
        end
        S_LEAF: begin
          if (rd_a.count == '0) begin
            res_status <= bmx_pkg::STATUS_ABSENT;
            state      <= S_FIN;
          end else begin
            key_sh <= key_q;
            left   <= bmx_pkg::LVL_BITS'(bmx_pkg::KEY_BITS);
            cur    <= '0;
            state  <= S_UPD;
          end
        end
        S_UPD: begin
          if (left == '0) begin
            fresh <= 1'b0;
            state <= S_FIN;
          end else begin
            key_sh <= key_sh << 1;
            left   <= left - bmx_pkg::LVL_BITS'(1);
            if (is_insert && nx == '0) begin
              cur   <= nf[bmx_pkg::NODE_BITS-1:0];
              nf    <= nf + (bmx_pkg::NODE_BITS+1)'(1);
              fresh <= 1'b1;
            end else begin
              cur   <= nx;
              fresh <= 1'b0;
            end
          end
        end
        S_QROOT: begin
          l0nz  <= (rd_a.link0 != '0);
          l1nz  <= (rd_a.link1 != '0);
          state <= S_QRY;
        end
        S_QRY: begin
          if (!c0nz && !c1nz) begin
            state <= S_FIN;
          end else begin
            acc    <= acc_next;
            key_sh <= key_sh << 1;
            left   <= left - bmx_pkg::LVL_BITS'(1);
            l0nz   <= (chosen.link0 != '0);
            l1nz   <= (chosen.link1 != '0);
            if (left == bmx_pkg::LVL_BITS'(1)) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_answer <= bmx_pkg::ANSWER_W'(acc);
            m_status <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/bmx_checker.sv
// Port-level checks of the binary trie maximum-xor block and their binding.
module bmx_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [bmx_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bmx_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic [bmx_pkg::STATUS_W-1:0] status;
  logic [bmx_pkg::ANSWER_W-1:0] answer;

  assign status = m_tdata[bmx_pkg::OUT_W-1:bmx_pkg::ANSWER_W];
  assign answer = m_tdata[bmx_pkg::ANSWER_W-1:0];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result transaction changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while previous command still in progress");

  a_flag_no_answer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != bmx_pkg::STATUS_OK |-> answer == '0)
    else $error("flagged result carries a non-zero answer");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block not quiet after reset");

endmodule

bind binary_trie_max_xor_top bmx_checker u_bmx_checker (.*);

>>> tb/tb.sv
// Self-checking testbench of the binary trie maximum-xor block, with its own trie predictor.
module tb;

  localparam logic [bmx_pkg::CMD_W-1:0]   CMD_UNUSED   = 2'd3;
  localparam int unsigned                 COUNT_TOP    = (1 << bmx_pkg::COUNT_BITS) - 1;
  localparam int                          STALL_LIMIT  = 5000;
  localparam int                          RANDOM_ITEMS = 600;
  localparam logic [bmx_pkg::VALUE_W-1:0] KEY_ONES     = {bmx_pkg::VALUE_W{1'b1}};

  typedef struct packed {
    logic [bmx_pkg::ANSWER_W-1:0] answer;
    logic [bmx_pkg::STATUS_W-1:0] status;
  } reply_t;

  class trie_scoreboard;
    int unsigned cnt [bmx_pkg::POOL_NODES];
    int unsigned link [2 * bmx_pkg::POOL_NODES];
    int unsigned free_node;
    reply_t      replies [$];
    int          errors;

    function new();
      for (int i = 0; i < bmx_pkg::POOL_NODES; i++) begin
        cnt[i] = 0;
        link[2 * i] = 0;
        link[2 * i + 1] = 0;
      end
      for (int i = 0; i <= bmx_pkg::KEY_BITS; i++) begin
        cnt[i] = 1;
        if (i < bmx_pkg::KEY_BITS) link[2 * i] = i + 1;
      end
      free_node = bmx_pkg::KEY_BITS + 1;
      errors = 0;
    endfunction

    function int unsigned weight(int unsigned n);
      return (n == 0) ? 0 : cnt[n];
    endfunction

    function int pending();
      return replies.size();
    endfunction

    function logic [bmx_pkg::STATUS_W-1:0] insert_key(logic [bmx_pkg::VALUE_W-1:0] v);
      int unsigned node;
      int unsigned nx;
      int unsigned missing;
      if (cnt[0] >= COUNT_TOP) return bmx_pkg::STATUS_SATURATED;
      node = 0;
      missing = 0;
      for (int lv = bmx_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
        nx = link[2 * node + v[lv]];
        if (nx == 0) begin
          missing = lv + 1;
          break;
        end
        node = nx;
      end
      if (free_node + missing > bmx_pkg::POOL_NODES) return bmx_pkg::STATUS_POOL_FULL;
      node = 0;
      cnt[0]++;
      for (int lv = bmx_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
        nx = link[2 * node + v[lv]];
        if (nx == 0) begin
          nx = free_node;
          free_node++;
          cnt[nx] = 0;
          link[2 * nx] = 0;
          link[2 * nx + 1] = 0;
          link[2 * node + v[lv]] = nx;
        end
        node = nx;
        cnt[node]++;
      end
      return bmx_pkg::STATUS_OK;
    endfunction

    function logic [bmx_pkg::STATUS_W-1:0] remove_key(logic [bmx_pkg::VALUE_W-1:0] v);
      int unsigned node;
      node = 0;
      for (int lv = bmx_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
        node = link[2 * node + v[lv]];
        if (node == 0) return bmx_pkg::STATUS_ABSENT;
      end
      if (weight(node) == 0) return bmx_pkg::STATUS_ABSENT;
      node = 0;
      cnt[0]--;
      for (int lv = bmx_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
        node = link[2 * node + v[lv]];
        cnt[node]--;
      end
      return bmx_pkg::STATUS_OK;
    endfunction

    function logic [bmx_pkg::ANSWER_W-1:0] best_xor(logic [bmx_pkg::VALUE_W-1:0] v);
      int unsigned node;
      int unsigned c0;
      int unsigned c1;
      int unsigned pick;
      int unsigned other;
      logic [63:0] acc;
      node = 0;
      acc = '0;
      for (int lv = bmx_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
        c0 = link[2 * node];
        c1 = link[2 * node + 1];
        if (weight(c0) == 0 && weight(c1) == 0) break;
        if (v[lv]) begin
          pick = c0;
          other = c1;
        end else begin
          pick = c1;
          other = c0;
        end
        if (weight(pick) != 0) begin
          acc = {acc[62:0], 1'b1};
          node = pick;
        end else begin
          acc = {acc[62:0], 1'b0};
          node = other;
        end
      end
      return acc[bmx_pkg::ANSWER_W-1:0];
    endfunction

    function void note_command(logic [bmx_pkg::IN_DATA_W-1:0] d);
      reply_t                      r;
      logic [bmx_pkg::CMD_W-1:0]   c;
      logic [bmx_pkg::VALUE_W-1:0] v;
      c = d[bmx_pkg::CMD_W-1:0];
      v = d[bmx_pkg::CMD_W +: bmx_pkg::VALUE_W];
      r.answer = '0;
      r.status = bmx_pkg::STATUS_OK;
      case (c)
        bmx_pkg::CMD_INSERT: r.status = insert_key(v);
        bmx_pkg::CMD_REMOVE: r.status = remove_key(v);
        bmx_pkg::CMD_QUERY:  r.answer = best_xor(v);
        default:             r = '0;
      endcase
      replies.push_back(r);
    endfunction

    function void check_result(logic [bmx_pkg::OUT_DATA_W-1:0] d);
      reply_t                       exp_r;
      logic [bmx_pkg::ANSWER_W-1:0] answer;
      logic [bmx_pkg::STATUS_W-1:0] status;
      answer = d[bmx_pkg::ANSWER_W-1:0];
      status = d[bmx_pkg::ANSWER_W +: bmx_pkg::STATUS_W];
      if (replies.size() == 0) begin
        $error("unexpected transaction: answer %h status %0d", answer, status);
        errors++;
        return;
      end
      exp_r = replies.pop_front();
      if (answer !== exp_r.answer) begin
        $error("answer: expected %h, actual %h", exp_r.answer, answer);
        errors++;
      end
      if (status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [bmx_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [bmx_pkg::OUT_DATA_W-1:0] m_tdata;

  trie_scoreboard              sb;
  bit                          quiet = 1'b0;
  int                          ready_hold = 0;
  int                          stall_cycles = 0;
  logic [bmx_pkg::VALUE_W-1:0] present_keys [$];

  binary_trie_max_xor_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int stretch_len();
    return ($urandom_range(0, 99) < 85) ? int'($urandom_range(1, 4))
                                        : int'($urandom_range(10, 60));
  endfunction

  function automatic int idle_gap();
    if (quiet || $urandom_range(0, 99) < 50) return 0;
    return stretch_len();
  endfunction

  function automatic logic [bmx_pkg::VALUE_W-1:0] known_key();
    return present_keys[$urandom_range(0, present_keys.size() - 1)];
  endfunction

  function automatic logic [bmx_pkg::VALUE_W-1:0] fresh_key();
    int roll;
    roll = int'($urandom_range(0, 2));
    if (present_keys.size() == 0 || roll == 0) return bmx_pkg::VALUE_W'($urandom);
    if (roll == 1) begin
      return known_key()
             ^ bmx_pkg::VALUE_W'($urandom & ((1 << $urandom_range(1, 12)) - 1));
    end
    return known_key();
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_command(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      m_tready <= 1'b0;
      ready_hold <= stretch_len();
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_command(input logic [bmx_pkg::CMD_W-1:0] c,
                              input logic [bmx_pkg::VALUE_W-1:0] v);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(bmx_pkg::IN_DATA_W - bmx_pkg::IN_W){1'b0}}, v, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic random_command();
    int                          roll;
    int                          idx;
    logic [bmx_pkg::VALUE_W-1:0] v;
    roll = int'($urandom_range(0, 99));
    if (roll < 40) begin
      v = fresh_key();
      push_command(bmx_pkg::CMD_INSERT, v);
      present_keys.push_back(v);
    end else if (roll < 70) begin
      if (present_keys.size() > 0 && $urandom_range(0, 99) < 80) begin
        idx = int'($urandom_range(0, present_keys.size() - 1));
        v = present_keys[idx];
        present_keys.delete(idx);
      end else begin
        v = fresh_key();
      end
      push_command(bmx_pkg::CMD_REMOVE, v);
    end else if (roll < 95) begin
      push_command(bmx_pkg::CMD_QUERY, $urandom_range(0, 1) ? fresh_key() : ~fresh_key());
    end else begin
      push_command(CMD_UNUSED, bmx_pkg::VALUE_W'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the single zero key, emptying the set, absent removes, extremes
    push_command(bmx_pkg::CMD_QUERY, '0);
    push_command(bmx_pkg::CMD_QUERY, KEY_ONES);
    push_command(bmx_pkg::CMD_REMOVE, '0);
    push_command(bmx_pkg::CMD_QUERY, 31'h0001_2345);
    push_command(bmx_pkg::CMD_REMOVE, '0);
    push_command(bmx_pkg::CMD_REMOVE, KEY_ONES);
    push_command(CMD_UNUSED, KEY_ONES);
    push_command(bmx_pkg::CMD_INSERT, KEY_ONES);
    push_command(bmx_pkg::CMD_INSERT, '0);
    push_command(bmx_pkg::CMD_INSERT, '0);
    push_command(bmx_pkg::CMD_QUERY, '0);
    push_command(bmx_pkg::CMD_QUERY, KEY_ONES);
    push_command(bmx_pkg::CMD_REMOVE, '0);
    push_command(bmx_pkg::CMD_QUERY, KEY_ONES);
    push_command(bmx_pkg::CMD_REMOVE, '0);
    push_command(bmx_pkg::CMD_QUERY, KEY_ONES);
    push_command(bmx_pkg::CMD_INSERT, 31'h5555_5555);
    push_command(bmx_pkg::CMD_QUERY, 31'h2AAA_AAAA);
    push_command(bmx_pkg::CMD_QUERY, 31'h5555_5554);
    push_command(bmx_pkg::CMD_REMOVE, 31'h5555_5554);
    push_command(bmx_pkg::CMD_INSERT, 31'h5555_5554);
    push_command(bmx_pkg::CMD_QUERY, 31'h0000_0001);
    push_command(CMD_UNUSED, '0);
    present_keys.push_back(KEY_ONES);
    present_keys.push_back(31'h5555_5555);
    present_keys.push_back(31'h5555_5554);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i / 100) % 3 == 2);
      if ($urandom_range(0, 99) < 3) drain_results();
      random_command();
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bmx_pkg.sv
rtl/core/bmx_node_mem.sv
rtl/core/binary_trie_max_xor_top.sv
rtl/core/bmx_checker.sv
tb/tb.sv
